[src/mpnc_pkg.sv]
// Shared package for the multi-pattern non-overlapping counter.
// Holds the fixed field widths, default parameter values, register indexes
// and the item type that travels from the front end to the back end.
package mpnc_pkg;

	// Fixed widths of the ports and configuration registers.
	localparam int NUM_SLOTS   = 4;
	localparam int TEXT_W      = 8;
	localparam int LEN_W       = 4;
	localparam int PAT_W       = 64;
	localparam int OUT_COUNT_W = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int LENGTHS_W   = 16;

	// Defaults for the top-level parameters.
	localparam int DEF_NUM_PATTERNS    = 4;
	localparam int DEF_MAX_PATTERN_LEN = 8;
	localparam int DEF_COUNT_BITS      = 20;

	// Entries in the queue between the front end and the back end.
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTHS   = 3'd4;

	// One classified text byte: which slots see a full pattern match
	// ending at this byte, and whether it closes the text.
	typedef struct packed {
		logic [NUM_SLOTS-1:0] hit;
		logic                 last;
	} mpnc_item_t;

endpackage

[src/multi_pattern_nonoverlap_counter.sv]
// Top level of the multi-pattern non-overlapping counter: configuration
// registers, front end, queue and back end. Depends on mpnc_pkg and on
// mpnc_front, mpnc_queue and mpnc_back.

// The block scans a text one byte per cycle and counts, for each of up to four
// patterns of 1 to 8 bytes, the non-overlapping occurrences chosen greedily
// from left to right; counts saturate. A byte is taken every cycle as long as
// the two-entry queue between the front end (byte window and compares) and the
// back end (hold-off counters and counts) has room. The transfer that carries
// end_of_text passes through the queue, behind any items still ahead of it, and
// then into the output register that yields the four counts. If the previous
// result still waits in the output register, that closing byte holds the back
// end until the result is transferred; the bytes behind it wait in the queue,
// and the input stalls while the queue is full. The user must write patterns
// and lengths only while the block is idle; the block does not enforce this.
module multi_pattern_nonoverlap_counter import mpnc_pkg::*; #(
	parameter int NUM_PATTERNS    = DEF_NUM_PATTERNS,
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
	parameter int COUNT_BITS      = DEF_COUNT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [TEXT_W-1:0]      text_byte,
	input  logic                   end_of_text,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUT_COUNT_W-1:0] count_a,
	output logic [OUT_COUNT_W-1:0] count_b,
	output logic [OUT_COUNT_W-1:0] count_c,
	output logic [OUT_COUNT_W-1:0] count_d
);

	logic [NUM_SLOTS-1:0][PAT_W-1:0]            pattern_q;
	logic [LENGTHS_W-1:0]                       lengths_q;
	logic [NUM_PATTERNS-1:0][PAT_W-1:0]         pattern;
	logic [NUM_PATTERNS-1:0][LEN_W-1:0]         eff_len;
	logic [NUM_PATTERNS-1:0][COUNT_BITS-1:0]    result;
	logic [NUM_SLOTS-1:0][OUT_COUNT_W-1:0]      count_out;
	logic                                       q_push;
	logic                                       q_pop;
	logic                                       q_full;
	logic                                       q_valid;
	mpnc_item_t                                 q_item;
	mpnc_item_t                                 q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			lengths_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_A: pattern_q[0] <= cfg_data;
				REG_PATTERN_B: pattern_q[1] <= cfg_data;
				REG_PATTERN_C: pattern_q[2] <= cfg_data;
				REG_PATTERN_D: pattern_q[3] <= cfg_data;
				REG_LENGTHS:   lengths_q    <= cfg_data[LENGTHS_W-1:0];
				default:       lengths_q    <= lengths_q;
			endcase
		end
	end

	// A length beyond the supported maximum disables its slot.
	always_comb begin
		for (int s = 0; s < NUM_PATTERNS; s++) begin
			pattern[s] = pattern_q[s];
			if (lengths_q[LEN_W*s +: LEN_W] > LEN_W'(MAX_PATTERN_LEN)) begin
				eff_len[s] = '0;
			end else begin
				eff_len[s] = lengths_q[LEN_W*s +: LEN_W];
			end
		end
	end

	mpnc_front #(
		.NUM_PATTERNS    (NUM_PATTERNS),
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.pattern     (pattern),
		.eff_len     (eff_len),
		.q_full      (q_full),
		.in_stall    (in_stall),
		.q_push      (q_push),
		.q_item      (q_item)
	);

	mpnc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.full      (q_full),
		.q_valid   (q_valid),
		.head      (q_head)
	);

	mpnc_back #(
		.NUM_PATTERNS    (NUM_PATTERNS),
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN),
		.COUNT_BITS      (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_len   (eff_len),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result    (result)
	);

	// Slots beyond the configured number report zero.
	always_comb begin
		for (int s = 0; s < NUM_SLOTS; s++) begin
			count_out[s] = '0;
		end
		for (int s = 0; s < NUM_PATTERNS; s++) begin
			count_out[s] = OUT_COUNT_W'(result[s]);
		end
	end

	assign count_a = count_out[0];
	assign count_b = count_out[1];
	assign count_c = count_out[2];
	assign count_d = count_out[3];

	// Bytes that do not close a text never wait in the queue head.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !q_head.last |-> q_pop)
		else $error("non-closing item held at the queue head");

	// A closing byte that was accepted is visible to the back end next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && end_of_text |=> q_valid)
		else $error("accepted closing byte missing from the queue");

	// A result appears only after the back end took a closing item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_pop && q_head.last))
		else $error("result raised without a closing item");

endmodule

[src/mpnc_front.sv]
// Front end of the multi-pattern counter: accepts text bytes, keeps the
// byte window and fill count, and classifies each byte into per-slot hits.
// Depends on mpnc_pkg.
module mpnc_front import mpnc_pkg::*; #(
	parameter int NUM_PATTERNS    = DEF_NUM_PATTERNS,
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [TEXT_W-1:0]                   text_byte,
	input  logic                                end_of_text,
	input  logic [NUM_PATTERNS-1:0][PAT_W-1:0]  pattern,
	input  logic [NUM_PATTERNS-1:0][LEN_W-1:0]  eff_len,
	input  logic                                q_full,
	output logic                                in_stall,
	output logic                                q_push,
	output mpnc_item_t                          q_item
);

	localparam int SEEN_W = $clog2(MAX_PATTERN_LEN + 1);
	localparam int IDX_W  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

	// Index 0 holds the newest byte.
	logic [MAX_PATTERN_LEN-1:0][TEXT_W-1:0] win_q;
	logic [MAX_PATTERN_LEN-1:0][TEXT_W-1:0] win_n;
	logic [SEEN_W-1:0]                      seen_q;
	logic [SEEN_W-1:0]                      seen_n;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		win_n[0] = text_byte;
		for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
			win_n[k] = win_q[k-1];
		end
		seen_n = (seen_q == SEEN_W'(MAX_PATTERN_LEN)) ? seen_q : seen_q + 1'b1;
	end

	// Pattern byte k must sit at age len-1-k in the window that includes
	// the incoming byte.
	always_comb begin : match_blk
		logic             ok;
		logic [IDX_W-1:0] age;
		q_item.hit  = '0;
		q_item.last = end_of_text;
		for (int s = 0; s < NUM_PATTERNS; s++) begin
			ok = 1'b1;
			for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
				age = IDX_W'(eff_len[s] - LEN_W'(k) - LEN_W'(1));
				if (LEN_W'(k) < eff_len[s]) begin
					if (win_n[age] != pattern[s][TEXT_W*k +: TEXT_W]) begin
						ok = 1'b0;
					end
				end
			end
			q_item.hit[s] = ok && (eff_len[s] != '0) && (LEN_W'(seen_n) >= eff_len[s]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			seen_q <= '0;
		end else if (q_push) begin
			if (end_of_text) begin
				win_q  <= '0;
				seen_q <= '0;
			end else begin
				win_q  <= win_n;
				seen_q <= seen_n;
			end
		end
	end

endmodule

[src/mpnc_queue.sv]
// Short queue between the front end and the back end of the counter.
// Holds classified items so either side can stall on its own.
// Depends on mpnc_pkg.
module mpnc_queue import mpnc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mpnc_item_t push_item,
	input  logic       pop,
	output logic       full,
	output logic       q_valid,
	output mpnc_item_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	mpnc_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/mpnc_back.sv]
// Back end of the multi-pattern counter: applies hits through the per-slot
// hold-off counters, keeps the saturating counts and registers the result.
// Depends on mpnc_pkg.
module mpnc_back import mpnc_pkg::*; #(
	parameter int NUM_PATTERNS    = DEF_NUM_PATTERNS,
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
	parameter int COUNT_BITS      = DEF_COUNT_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic [NUM_PATTERNS-1:0][LEN_W-1:0]       eff_len,
	input  logic                                     q_valid,
	input  mpnc_item_t                               q_head,
	output logic                                     q_pop,
	input  logic                                     out_stall,
	output logic                                     out_valid,
	output logic [NUM_PATTERNS-1:0][COUNT_BITS-1:0]  result
);

	localparam int HOLD_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

	logic [NUM_PATTERNS-1:0][HOLD_W-1:0]     hold_q;
	logic [NUM_PATTERNS-1:0][HOLD_W-1:0]     hold_n;
	logic [NUM_PATTERNS-1:0][COUNT_BITS-1:0] cnt_q;
	logic [NUM_PATTERNS-1:0][COUNT_BITS-1:0] cnt_n;
	logic [NUM_PATTERNS-1:0][COUNT_BITS-1:0] result_q;
	logic                                    out_valid_q;

	// Only a closing item needs the result register; others always drain.
	assign q_pop     = q_valid && (!q_head.last || !out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_comb begin
		for (int s = 0; s < NUM_PATTERNS; s++) begin
			hold_n[s] = hold_q[s];
			cnt_n[s]  = cnt_q[s];
			if (hold_q[s] != '0) begin
				hold_n[s] = hold_q[s] - 1'b1;
			end else if (q_head.hit[s]) begin
				if (cnt_q[s] != '1) begin
					cnt_n[s] = cnt_q[s] + 1'b1;
				end
				hold_n[s] = HOLD_W'(eff_len[s] - LEN_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.last) begin
			for (int s = 0; s < NUM_PATTERNS; s++) begin
				result_q[s] <= (eff_len[s] == '0) ? '0 : cnt_n[s];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_head.last) begin
					hold_q <= '0;
					cnt_q  <= '0;
				end else begin
					hold_q <= hold_n;
					cnt_q  <= cnt_n;
				end
			end
			if (q_pop && q_head.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[tb/sv/tb_multi_pattern_nonoverlap_counter.sv]
// Self-checking testbench for multi_pattern_nonoverlap_counter: streams texts through the
// byte channel under random idling and checks every set of counts against a local predictor.
// Depends on mpnc_pkg and the counter RTL.
module tb_multi_pattern_nonoverlap_counter;
	timeunit 1ns;
	timeprecision 1ps;
	import mpnc_pkg::*;

	localparam int NUM_PAT = DEF_NUM_PATTERNS;
	localparam int MAX_LEN = DEF_MAX_PATTERN_LEN;
	localparam int CNT_BITS = DEF_COUNT_BITS;
	localparam logic [63:0] COUNT_MAX = (64'd1 << CNT_BITS) - 64'd1;
	localparam int RESET_CYCLES = 6;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SEGMENTS = 16;
	localparam int SEG_ITEMS = 94;

	typedef struct {
		logic [TEXT_W-1:0] data;
		logic              last;
	} text_xfer_t;

	typedef logic [NUM_SLOTS-1:0][OUT_COUNT_W-1:0] slot_counts_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_PATTERN_A;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [TEXT_W-1:0]      text_byte = '0;
	logic                   end_of_text = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [OUT_COUNT_W-1:0] count_a, count_b, count_c, count_d;

	text_xfer_t   byte_queue [$];
	slot_counts_t pending_counts [$];
	int unsigned  items_queued = 0;
	int unsigned  mismatches = 0;
	int unsigned  cycle_cnt = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;

	// Shadow configuration and scan state of the predictor.
	logic [PAT_W-1:0]     shadow_pattern [NUM_SLOTS];
	logic [LENGTHS_W-1:0] shadow_lengths = '0;
	logic [PAT_W-1:0]     scan_window = '0;
	int unsigned          scan_fill = 0;
	int unsigned          slot_hold [NUM_SLOTS];
	logic [63:0]          slot_count [NUM_SLOTS];

	multi_pattern_nonoverlap_counter #(
		.NUM_PATTERNS(NUM_PAT),
		.MAX_PATTERN_LEN(MAX_LEN),
		.COUNT_BITS(CNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.count_a(count_a),
		.count_b(count_b),
		.count_c(count_c),
		.count_d(count_d)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_scan();
		scan_window = '0;
		scan_fill = 0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			slot_hold[s] = 0;
			slot_count[s] = '0;
		end
	endfunction

	// A length above the supported maximum, or a slot beyond NUM_PATTERNS, is disabled.
	function automatic int unsigned slot_length(int s);
		int unsigned len;
		len = 32'(shadow_lengths[4*s +: 4]);
		if (s >= NUM_PAT || len > MAX_LEN || len > 8)
			return 0;
		return len;
	endfunction

	function automatic bit window_hit(int s, int unsigned len);
		for (int unsigned k = 0; k < len; k++)
			if (scan_window[8*(len-1-k) +: 8] != shadow_pattern[s][8*k +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic scan_text_byte(input logic [TEXT_W-1:0] data, input logic last);
		int unsigned  len;
		slot_counts_t result;
		scan_window = {scan_window[PAT_W-9:0], data};
		if (scan_fill < 8)
			scan_fill++;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			len = slot_length(s);
			// The hold-off blocks every byte that would close an overlapping match.
			if (slot_hold[s] != 0) begin
				slot_hold[s]--;
			end else if (len != 0 && scan_fill >= len && window_hit(s, len)) begin
				if (slot_count[s] < COUNT_MAX)
					slot_count[s]++;
				slot_hold[s] = (len - 1) & 7;
			end
		end
		if (last) begin
			for (int s = 0; s < NUM_SLOTS; s++)
				result[s] = (slot_length(s) == 0) ? '0 : slot_count[s][OUT_COUNT_W-1:0];
			pending_counts.insert(pending_counts.size(), result);
			clear_scan();
		end
	endtask

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic queue_byte(input logic [TEXT_W-1:0] data, input logic last);
		text_xfer_t x;
		x.data = data;
		x.last = last;
		byte_queue.insert(byte_queue.size(), x);
		items_queued++;
	endtask

	// Mostly bytes from a two-symbol alphabet so that the patterns hit often.
	task automatic queue_random_text(input logic [7:0] sym0, input logic [7:0] sym1,
			input int unsigned max_len);
		int unsigned len;
		logic [7:0]  data;
		len = $urandom_range(max_len, 1);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(19) < 3)
				data = 8'($urandom);
			else
				data = $urandom_range(1) ? sym1 : sym0;
			queue_byte(data, i == len - 1);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LENGTHS)
			shadow_lengths = val[LENGTHS_W-1:0];
		else
			shadow_pattern[idx[1:0]] = val;
	endtask

	// Conditions are sampled on the falling edge, after every rising-edge update has settled.
	task automatic wait_idle();
		while (byte_queue.size() != 0 || in_valid || pending_counts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: the predictor sees each transfer at the edge where it happens.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				scan_text_byte(text_byte, end_of_text);
			if (!in_valid || !in_stall) begin
				if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					text_byte <= byte_queue[0].data;
					end_of_text <= byte_queue[0].last;
					void'(byte_queue.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		slot_counts_t got, want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				got = {count_d, count_c, count_b, count_a};
				if (pending_counts.size() == 0) begin
					flag_mismatch("counts transferred with none expected");
				end else begin
					want = pending_counts.pop_front();
					for (int s = 0; s < NUM_SLOTS; s++)
						if (got[s] !== want[s])
							flag_mismatch($sformatf("slot %0d count %0d, expected %0d",
								s, got[s], want[s]));
				end
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [7:0]           sym0, sym1;
		logic [PAT_W-1:0]     pat;
		logic [LENGTHS_W-1:0] lens;
		int unsigned          seg_start;
		int unsigned          r;
		bit                   paused;

		for (int s = 0; s < NUM_SLOTS; s++)
			shadow_pattern[s] = '0;
		clear_scan();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Every slot is disabled out of reset.
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		wait_idle();
		write_reg(REG_PATTERN_A, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_PATTERN_B, 64'h0);
		write_reg(REG_PATTERN_C, 64'h6161);
		write_reg(REG_PATTERN_D, 64'h0123_4567_89AB_CD61);
		write_reg(REG_LENGTHS, 16'h9218);
		// A run of five equal bytes holds two non-overlapping copies of the pair.
		repeat (4) queue_byte(8'h61, 1'b0);
		queue_byte(8'h61, 1'b1);
		// Text shorter than the eight-byte pattern.
		repeat (2) queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b1);
		repeat (8) queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'h00, 1'b1);
		// Lengths change in the middle of a text; the scan state carries over.
		repeat (2) queue_byte(8'h61, 1'b0);
		wait_idle();
		write_reg(REG_LENGTHS, 16'h1208);
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h61, 1'b1);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_idle();
			case (seg % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 59;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 59;
				end
				default: begin
					send_idle_pct = 7;
					recv_stall_pct = 7;
				end
			endcase
			sym0 = 8'($urandom);
			sym1 = 8'($urandom);
			if (seg == 0) begin
				sym0 = 8'hFF;
				sym1 = 8'hFF;
			end else if (seg == 1) begin
				sym0 = 8'h00;
				sym1 = 8'h00;
			end
			for (int s = 0; s < NUM_SLOTS; s++) begin
				for (int k = 0; k < 8; k++)
					pat[8*k +: 8] = ($urandom_range(9) == 0) ? 8'($urandom) :
						($urandom_range(1) ? sym1 : sym0);
				if (seg < 2)
					pat = {8{sym0}};
				write_reg(REG_PATTERN_A + CFG_IDX_W'(s), pat);
			end
			for (int s = 0; s < NUM_SLOTS; s++) begin
				r = $urandom_range(9);
				if (r == 0)
					lens[4*s +: 4] = 4'd0;
				else if (r == 1)
					lens[4*s +: 4] = 4'($urandom_range(15, 9));
				else
					lens[4*s +: 4] = 4'($urandom_range(8, 1));
			end
			if (seg == 0)
				lens = 16'h8888;
			else if (seg == 1)
				lens = 16'hFFFF;
			else if (seg == 2)
				lens = 16'h1111;
			write_reg(REG_LENGTHS, lens);

			seg_start = items_queued;
			paused = 1'b0;
			while (items_queued - seg_start < SEG_ITEMS) begin
				// Halfway through, the sender holds off until every count has come back.
				if (!paused && items_queued - seg_start >= SEG_ITEMS / 2) begin
					paused = 1'b1;
					wait_idle();
				end
				queue_random_text(sym0, sym1, ($urandom_range(7) == 0) ? 64 : 20);
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
